### rtl/hrsp_pkg.sv
package hrsp_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 4096;
  localparam int unsigned PATH_BYTES_DEF   = 256;
  localparam int unsigned BODY_BYTES_DEF   = 1024;
  localparam int unsigned MAX_HEADERS_DEF  = 16;

  localparam int unsigned NAME_CUT   = 63;
  localparam int unsigned VALUE_CUT  = 255;
  localparam int unsigned HOLD_DEPTH = 7;
  localparam int unsigned METH_COUNT = 5;

  typedef enum logic [2:0] {
    ROLE_OTHER     = 3'd0,
    ROLE_PATH      = 3'd1,
    ROLE_NAME      = 3'd2,
    ROLE_VALUE     = 3'd3,
    ROLE_TERM      = 3'd4,
    ROLE_BODY_KEEP = 3'd5,
    ROLE_BODY_DROP = 3'd6
  } role_t;

  typedef enum logic [2:0] {
    METH_GET     = 3'd0,
    METH_POST    = 3'd1,
    METH_PUT     = 3'd2,
    METH_DELETE  = 3'd3,
    METH_HEAD    = 3'd4,
    METH_UNKNOWN = 3'd5
  } method_t;

  typedef enum logic [7:0] {
    PH_METHOD = 8'b0000_0001,
    PH_PATH   = 8'b0000_0010,
    PH_SKIP   = 8'b0000_0100,
    PH_NAME   = 8'b0000_1000,
    PH_SEP    = 8'b0001_0000,
    PH_VALUE  = 8'b0010_0000,
    PH_DRAIN  = 8'b0100_0000,
    PH_BODY   = 8'b1000_0000
  } phase_t;

  localparam logic [7:0]  CH_CR    = 8'h0D;
  localparam logic [7:0]  CH_LF    = 8'h0A;
  localparam logic [7:0]  CH_SP    = 8'h20;
  localparam logic [7:0]  CH_COLON = 8'h3A;
  localparam logic [23:0] TAIL_END = 24'h0D0A0D;

  localparam logic [7:0] CL_NAME [14] = '{
    "c", "o", "n", "t", "e", "n", "t", "-", "l", "e", "n", "g", "t", "h"
  };
  localparam logic [7:0] CN_NAME [10] = '{
    "c", "o", "n", "n", "e", "c", "t", "i", "o", "n"
  };
  localparam logic [7:0] CLOSE_WORD [5] = '{"c", "l", "o", "s", "e"};

  localparam logic [7:0] METH_TEXT [METH_COUNT][HOLD_DEPTH] = '{
    '{"G", "E", "T", " ", 8'h00, 8'h00, 8'h00},
    '{"P", "O", "S", "T", " ", 8'h00, 8'h00},
    '{"P", "U", "T", " ", 8'h00, 8'h00, 8'h00},
    '{"D", "E", "L", "E", "T", "E", " "},
    '{"H", "E", "A", "D", " ", 8'h00, 8'h00}
  };
  localparam logic [2:0] METH_LEN [METH_COUNT] = '{3'd4, 3'd5, 3'd4, 3'd7, 3'd5};

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic is_eol(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

### rtl/hrsp_if.sv
interface hrsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source(output valid, output data_byte, input ready);
  modport sink(input valid, input data_byte, output ready);
endinterface

interface hrsp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_role;
  logic [7:0]  byte_out;
  logic [2:0]  method;
  logic        request_done;
  logic [31:0] content_length;
  logic        conn_persist;
  logic [4:0]  header_total;
  logic [12:0] consumed_bytes;
  logic        overflow_error;
  logic        last_of_run;
  modport source(output valid, output byte_role, output byte_out, output method,
                 output request_done, output content_length, output conn_persist,
                 output header_total, output consumed_bytes, output overflow_error,
                 output last_of_run, input ready);
  modport sink(input valid, input byte_role, input byte_out, input method,
               input request_done, input content_length, input conn_persist,
               input header_total, input consumed_bytes, input overflow_error,
               input last_of_run, output ready);
endinterface

### rtl/http_request_stream_parser.sv
// Channel   Dir  Payload                                         Handshake
// stream    in   data_byte                                       valid/ready
// result    out  byte_role, byte_out, method, request_done,      valid/ready
//                content_length, conn_persist, header_total,
//                consumed_bytes, overflow_error, last_of_run
//
// While the result register is free, one byte per cycle is classified by one
// pass of logic into it. While the method prefix is undecided (up to 7
// bytes) no result leaves; once decided, the held bytes replay one per cycle
// likewise, with stream.ready low. A synchronous reset returns the parser to
// the request line start. A stalled result register holds its transaction
// and stalls the input; a taken result frees it in the same cycle.
module http_request_stream_parser #(
  parameter int unsigned BUFFER_BYTES = hrsp_pkg::BUFFER_BYTES_DEF,
  parameter int unsigned PATH_BYTES   = hrsp_pkg::PATH_BYTES_DEF,
  parameter int unsigned BODY_BYTES   = hrsp_pkg::BODY_BYTES_DEF,
  parameter int unsigned MAX_HEADERS  = hrsp_pkg::MAX_HEADERS_DEF
) (
  input logic          clk,
  input logic          rst,
  hrsp_byte_if.sink    stream,
  hrsp_result_if.source result
);
  import hrsp_pkg::*;

  localparam int unsigned FP_W = ($clog2(PATH_BYTES) > 9) ? $clog2(PATH_BYTES) : 9;
  localparam int unsigned BC_W = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned HC_W = $clog2(MAX_HEADERS + 1);
  localparam logic [FP_W-1:0] PATH_LIM = FP_W'(PATH_BYTES - 1);
  localparam logic [31:0]     BODY_LIM = 32'(BODY_BYTES - 1);
  localparam logic [BC_W-1:0] BUF_LIM  = BC_W'(BUFFER_BYTES);
  localparam logic [HC_W-1:0] HDR_LIM  = HC_W'(MAX_HEADERS);

  // parser state
  logic [7:0]      hold [HOLD_DEPTH];
  logic [7:0]      hold_next [HOLD_DEPTH];
  phase_t          phase, phase_next;
  logic [BC_W-1:0] byte_count, byte_count_next;
  logic [23:0]     tail, tail_next;
  logic [FP_W-1:0] fp, fp_next;
  logic [HC_W-1:0] hc, hc_next;
  logic [3:0]      flags, flags_next;
  logic [31:0]     len, len_next;
  logic [31:0]     rem, rem_next;
  logic            close_seen, close_seen_next;
  method_t         meth, meth_next;
  logic            replay_active, replay_active_next;
  logic            replay_full, replay_full_next;
  logic [2:0]      replay_idx, replay_idx_next;
  logic [2:0]      replay_len, replay_len_next;

  // result register
  logic        out_valid, out_valid_next;
  logic [2:0]  out_role;
  logic [7:0]  out_byte;
  logic [2:0]  out_method;
  logic        out_done;
  logic [31:0] out_length;
  logic        out_keep;
  logic [4:0]  out_headers;
  logic [12:0] out_consumed;
  logic        out_overflow;
  logic        out_last;

  logic        out_free, accept, emit;
  logic [7:0]  b;

  // classifier results
  phase_t          cls_phase;
  logic [FP_W-1:0] cls_fp;
  logic [HC_W-1:0] cls_hc;
  logic [3:0]      cls_flags;
  logic [31:0]     cls_len, cls_rem;
  logic            cls_close, cls_done;
  logic [23:0]     cls_tail;
  role_t           cls_role;

  assign out_free     = !out_valid || result.ready;
  assign stream.ready = out_free && !replay_active;
  assign accept       = stream.valid && stream.ready;
  assign b            = replay_active ? hold[replay_idx] : stream.data_byte;

  always_comb begin
    logic [7:0]  lc;
    logic        stop, do_value, endm, eq14, eq10;
    logic [35:0] prod;
    lc        = to_lower(b);
    cls_phase = phase;
    cls_fp    = fp;
    cls_hc    = hc;
    cls_flags = flags;
    cls_len   = len;
    cls_rem   = rem;
    cls_close = close_seen;
    cls_done  = 1'b0;
    cls_tail  = tail;
    cls_role  = ROLE_OTHER;
    stop      = 1'b0;
    do_value  = 1'b0;
    eq14      = 1'b0;
    eq10      = 1'b0;
    prod      = '0;
    endm      = (tail == TAIL_END) && (b == CH_LF);
    if (phase == PH_BODY) begin
      cls_role = ((len - rem) < BODY_LIM) ? ROLE_BODY_KEEP : ROLE_BODY_DROP;
      if (rem != 32'd0) cls_rem = rem - 32'd1;
      if (cls_rem == 32'd0) cls_done = 1'b1;
    end else begin
      cls_tail = {tail[15:0], b};
      unique case (phase)
        PH_PATH: begin
          if (b == CH_SP) begin
            cls_phase = PH_SKIP;
          end else if (is_eol(b)) begin
            cls_role = ROLE_TERM;
            if (b == CH_LF) begin
              cls_phase = PH_NAME;
              cls_fp    = '0;
            end else begin
              cls_phase = PH_SKIP;
            end
          end else begin
            cls_role = ROLE_PATH;
            cls_fp   = fp + 1'b1;
            if (cls_fp >= PATH_LIM) cls_phase = PH_SKIP;
          end
        end
        PH_NAME: begin
          if (fp == '0) begin
            if (is_eol(b)) begin
              cls_phase = PH_DRAIN;
              cls_role  = ROLE_TERM;
              stop      = 1'b1;
            end else if (hc >= HDR_LIM) begin
              cls_phase = PH_SKIP;
              stop      = 1'b1;
            end else begin
              cls_hc    = hc + 1'b1;
              cls_flags = cls_flags | 4'b0011;
            end
          end
          if (!stop) begin
            if (b == CH_COLON || b == CH_CR) begin
              // close the name: candidates must match the full length
              eq14      = cls_flags[0] && (fp == FP_W'(14)) && !cls_flags[2];
              eq10      = cls_flags[1] && (fp == FP_W'(10)) && !cls_flags[3];
              cls_flags = {cls_flags[3:2], 2'b00} | {eq10, eq14, eq10, eq14};
              cls_fp    = '0;
              if (b == CH_COLON) begin
                cls_phase = PH_SEP;
              end else begin
                cls_flags = {cls_flags[3:2], 2'b00};
                cls_phase = PH_SKIP;
                cls_role  = ROLE_TERM;
              end
            end else begin
              cls_role = ROLE_NAME;
              if (!(fp < FP_W'(14) && lc == CL_NAME[fp[3:0]])) cls_flags[0] = 1'b0;
              if (!(fp < FP_W'(10) && lc == CN_NAME[fp[3:0]])) cls_flags[1] = 1'b0;
              cls_fp = fp + 1'b1;
              if (cls_fp >= FP_W'(NAME_CUT)) begin
                eq14      = cls_flags[0] && (cls_fp == FP_W'(14)) && !cls_flags[2];
                eq10      = cls_flags[1] && (cls_fp == FP_W'(10)) && !cls_flags[3];
                cls_flags = {cls_flags[3:2], 2'b00} | {eq10, eq14, eq10, eq14};
                cls_fp    = '0;
                cls_phase = PH_SEP;
              end
            end
          end
        end
        PH_SEP: begin
          if (!(b == CH_COLON || b == CH_SP)) do_value = 1'b1;
        end
        PH_VALUE: do_value = 1'b1;
        PH_DRAIN: cls_role = is_eol(b) ? ROLE_TERM : ROLE_OTHER;
        PH_SKIP, PH_METHOD, PH_BODY: begin
          if (b == CH_LF) begin
            cls_phase = PH_NAME;
            cls_fp    = '0;
            cls_role  = ROLE_TERM;
          end else if (b == CH_CR) begin
            cls_role = ROLE_TERM;
          end
        end
        default: cls_role = ROLE_OTHER;
      endcase
      if (do_value) begin
        cls_phase = PH_VALUE;
        if (is_eol(b)) begin
          if (flags[1] && fp == FP_W'(5)) cls_close = 1'b1;
          cls_flags = {flags[3:2], 2'b00};
          cls_role  = ROLE_TERM;
          if (b == CH_CR) begin
            cls_phase = PH_SKIP;
          end else begin
            cls_phase = PH_NAME;
            cls_fp    = '0;
          end
        end else begin
          cls_role = ROLE_VALUE;
          if (flags[0]) begin
            if (b >= "0" && b <= "9") begin
              prod    = {4'b0, len} * 36'd10 + {32'b0, b[3:0]};
              cls_len = (prod[35:32] != 4'd0) ? 32'hFFFF_FFFF : prod[31:0];
            end else begin
              cls_flags[0] = 1'b0;
            end
          end
          if (flags[1] && !(fp < FP_W'(5) && lc == CLOSE_WORD[fp[2:0]])) begin
            cls_flags[1] = 1'b0;
          end
          cls_fp = fp + 1'b1;
          if (cls_fp >= FP_W'(VALUE_CUT)) begin
            if (cls_flags[1] && cls_fp == FP_W'(5)) cls_close = 1'b1;
            cls_flags = {cls_flags[3:2], 2'b00};
            cls_phase = PH_SKIP;
          end
        end
      end
      if (endm) begin
        if (cls_flags[2] && cls_len != 32'd0) begin
          cls_phase = PH_BODY;
          cls_rem   = cls_len;
        end else begin
          cls_done = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic [7:0]      hold_new [HOLD_DEPTH];
    logic [2:0]      cnt;
    logic            any, full, mt, last, done, clear;
    method_t         full_m;
    logic [BC_W-1:0] bc_now;
    role_t           role;
    logic [BC_W+12:0] bc_ext;
    logic [HC_W+4:0]  hc_ext;
    hold_next          = hold;
    phase_next         = phase;
    tail_next          = tail;
    fp_next            = fp;
    hc_next            = hc;
    flags_next         = flags;
    len_next           = len;
    rem_next           = rem;
    close_seen_next    = close_seen;
    meth_next          = meth;
    replay_active_next = replay_active;
    replay_full_next   = replay_full;
    replay_idx_next    = replay_idx;
    replay_len_next    = replay_len;
    hold_new           = hold;
    cnt                = '0;
    any                = 1'b0;
    full               = 1'b0;
    mt                 = 1'b0;
    full_m             = METH_UNKNOWN;
    emit               = 1'b0;
    last               = 1'b0;
    done               = 1'b0;
    clear              = 1'b0;
    role               = ROLE_OTHER;
    bc_now             = accept ? byte_count + 1'b1 : byte_count;

    if (replay_active && out_free) begin
      emit            = 1'b1;
      last            = (replay_idx == replay_len - 3'd1);
      replay_idx_next = replay_idx + 3'd1;
      if (last) replay_active_next = 1'b0;
      if (replay_full) begin
        tail_next = {tail[15:0], b};
      end else begin
        role = cls_role;
        done = cls_done;
      end
    end else if (accept) begin
      if (phase == PH_METHOD) begin
        hold_new[fp[2:0]] = b;
        cnt = fp[2:0] + 3'd1;
        for (int m = 0; m < METH_COUNT; m++) begin
          mt = (cnt <= METH_LEN[m]);
          for (int i = 0; i < HOLD_DEPTH; i++) begin
            if (3'(i) < cnt && hold_new[i] != METH_TEXT[m][i]) mt = 1'b0;
          end
          any = any | mt;
          if (mt && cnt == METH_LEN[m]) begin
            full   = 1'b1;
            full_m = method_t'(3'(m));
          end
        end
        hold_next = hold_new;
        fp_next   = FP_W'(cnt);
        if (full || !any || cnt == 3'(HOLD_DEPTH)) begin
          // prefix decided: replay the held bytes
          meth_next          = full ? full_m : METH_UNKNOWN;
          phase_next         = PH_PATH;
          fp_next            = '0;
          replay_active_next = 1'b1;
          replay_full_next   = full;
          replay_idx_next    = '0;
          replay_len_next    = cnt;
        end
      end else begin
        emit = 1'b1;
        last = 1'b1;
        role = cls_role;
        done = cls_done;
      end
    end

    if (emit && !(replay_active && replay_full)) begin
      phase_next      = cls_phase;
      tail_next       = cls_tail;
      fp_next         = cls_fp;
      hc_next         = cls_hc;
      flags_next      = cls_flags;
      len_next        = cls_len;
      rem_next        = cls_rem;
      close_seen_next = cls_close;
    end

    bc_ext = {13'b0, bc_now};
    hc_ext = {5'b0, hc_next};
    byte_count_next = bc_now;
    if (emit && last && (done || bc_now >= BUF_LIM)) clear = 1'b1;

    out_valid_next = emit ? 1'b1 : (result.ready ? 1'b0 : out_valid);
    out_role       = role;
    out_byte       = b;
    out_method     = meth_next;
    out_done       = emit && last && done;
    out_length     = len_next;
    out_keep       = !close_seen_next;
    out_headers    = hc_ext[4:0];
    out_consumed   = (emit && last && done) ? bc_ext[12:0] : 13'd0;
    out_overflow   = emit && last && !done && (bc_now >= BUF_LIM);
    out_last       = last;

    if (clear) begin
      for (int i = 0; i < HOLD_DEPTH; i++) hold_next[i] = 8'h00;
      phase_next         = PH_METHOD;
      byte_count_next    = '0;
      tail_next          = '0;
      fp_next            = '0;
      hc_next            = '0;
      flags_next         = '0;
      len_next           = '0;
      rem_next           = '0;
      close_seen_next    = 1'b0;
      meth_next          = METH_UNKNOWN;
      replay_active_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HOLD_DEPTH; i++) hold[i] <= 8'h00;
      phase         <= PH_METHOD;
      byte_count    <= '0;
      tail          <= '0;
      fp            <= '0;
      hc            <= '0;
      flags         <= '0;
      len           <= '0;
      rem           <= '0;
      close_seen    <= 1'b0;
      meth          <= METH_UNKNOWN;
      replay_active <= 1'b0;
      replay_full   <= 1'b0;
      replay_idx    <= '0;
      replay_len    <= '0;
      out_valid     <= 1'b0;
    end else begin
      hold          <= hold_next;
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      tail          <= tail_next;
      fp            <= fp_next;
      hc            <= hc_next;
      flags         <= flags_next;
      len           <= len_next;
      rem           <= rem_next;
      close_seen    <= close_seen_next;
      meth          <= meth_next;
      replay_active <= replay_active_next;
      replay_full   <= replay_full_next;
      replay_idx    <= replay_idx_next;
      replay_len    <= replay_len_next;
      out_valid     <= out_valid_next;
    end
  end

  // payload of the result register: load on each emitted transaction
  always_ff @(posedge clk) begin
    if (emit) begin
      result.byte_role      <= out_role;
      result.byte_out       <= out_byte;
      result.method         <= out_method;
      result.request_done   <= out_done;
      result.content_length <= out_length;
      result.conn_persist   <= out_keep;
      result.header_total   <= out_headers;
      result.consumed_bytes <= out_consumed;
      result.overflow_error <= out_overflow;
      result.last_of_run    <= out_last;
    end
  end

  assign result.valid = out_valid;

  a_replay_blocks_input: assert property (@(posedge clk) disable iff (rst)
    replay_active |-> !stream.ready)
    else $error("input ready during prefix replay");

  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (rem != 32'd0))
    else $error("body phase with no bytes remaining");

  a_header_bound: assert property (@(posedge clk) disable iff (rst)
    hc <= HDR_LIM)
    else $error("header count past limit");

  a_replay_in_path: assert property (@(posedge clk) disable iff (rst)
    replay_active |-> (phase != PH_METHOD) && (replay_idx < replay_len))
    else $error("replay outside path phase");

endmodule

### dv/hrsp_tb_if.sv
interface hrsp_tb_clkgen;
  timeunit 1ns;
  timeprecision 1ps;
  logic clk;
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end
endinterface

### dv/http_request_stream_parser_tb.sv
module http_request_stream_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hrsp_pkg::*;

  typedef struct packed {
    role_t       role;
    logic [7:0]  data;
    method_t     meth;
    logic        done;
    logic [31:0] clen;
    logic        keep;
    logic [4:0]  hdrs;
    logic [12:0] consumed;
    logic        ovf;
    logic        last;
  } parse_res_t;

  class parse_scoreboard;
    // parser state mirror
    logic [7:0]  hold [7];
    phase_t      phase;
    int unsigned nbytes, tail, fpos, hcount, lval, body_left;
    logic [3:0]  flags;
    logic        closed;
    method_t     mcode;
    parse_res_t  pending [$];
    int          errors;
    bit          fin;

    function void clear();
      foreach (hold[i]) hold[i] = 8'h00;
      phase = PH_METHOD;
      nbytes = 0; tail = 0; fpos = 0; hcount = 0; flags = 4'h0;
      lval = 0; body_left = 0; closed = 1'b0; mcode = METH_UNKNOWN;
    endfunction

    function void push(role_t r, logic [7:0] b);
      parse_res_t e;
      e = '0;
      e.role = r; e.data = b; e.meth = mcode; e.clen = lval;
      e.keep = ~closed; e.hdrs = hcount[4:0];
      pending.push_back(e);
    endfunction

    function void close_name();
      logic cl, cn;
      cl = flags[0] && fpos == 14 && !flags[2];
      cn = flags[1] && fpos == 10 && !flags[3];
      flags = flags & 4'hC;
      if (cl) flags = flags | 4'h5;
      if (cn) flags = flags | 4'hA;
      fpos = 0;
    endfunction

    function void close_value();
      if (flags[1] && fpos == 5) closed = 1'b1;
      flags = flags & 4'hC;
    endfunction

    function role_t line_skip(logic [7:0] b);
      if (b == CH_LF) begin
        phase = PH_NAME; fpos = 0; return ROLE_TERM;
      end
      return (b == CH_CR) ? ROLE_TERM : ROLE_OTHER;
    endfunction

    function role_t value_char(logic [7:0] b);
      longint unsigned t;
      if (is_eol(b)) begin
        close_value();
        if (b == CH_CR) phase = PH_SKIP;
        else begin phase = PH_NAME; fpos = 0; end
        return ROLE_TERM;
      end
      if (flags[0]) begin
        if (b >= "0" && b <= "9") begin
          t = longint'(lval) * 10 + (b - "0");
          lval = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
        end else flags[0] = 1'b0;
      end
      if (flags[1] && !(fpos < 5 && to_lower(b) == CLOSE_WORD[fpos])) flags[1] = 1'b0;
      fpos++;
      if (fpos >= VALUE_CUT) begin close_value(); phase = PH_SKIP; end
      return ROLE_VALUE;
    endfunction

    function role_t name_char(logic [7:0] b);
      logic [7:0] lc;
      if (fpos == 0) begin
        if (is_eol(b)) begin phase = PH_DRAIN; return ROLE_TERM; end
        if (hcount >= MAX_HEADERS_DEF) begin phase = PH_SKIP; return ROLE_OTHER; end
        hcount++;
        flags = flags | 4'h3;
      end
      if (b == CH_COLON) begin close_name(); phase = PH_SEP; return ROLE_OTHER; end
      if (b == CH_CR) begin
        close_name(); close_value(); phase = PH_SKIP; return ROLE_TERM;
      end
      lc = to_lower(b);
      if (!(fpos < 14 && lc == CL_NAME[fpos])) flags[0] = 1'b0;
      if (!(fpos < 10 && lc == CN_NAME[fpos])) flags[1] = 1'b0;
      fpos++;
      if (fpos >= NAME_CUT) begin close_name(); phase = PH_SEP; end
      return ROLE_NAME;
    endfunction

    function role_t classify(logic [7:0] b);
      logic  at_end;
      role_t r;
      at_end = (tail == TAIL_END) && b == CH_LF;
      if (phase == PH_BODY) begin
        r = ((lval - body_left) < BODY_BYTES_DEF - 1) ? ROLE_BODY_KEEP : ROLE_BODY_DROP;
        if (body_left > 0) body_left--;
        if (body_left == 0) fin = 1;
        return r;
      end
      tail = ((tail << 8) | b) & 32'hFF_FFFF;
      case (phase)
        PH_PATH: begin
          if (b == CH_SP) begin phase = PH_SKIP; r = ROLE_OTHER; end
          else if (is_eol(b)) begin
            r = line_skip(b);
            if (b == CH_CR) phase = PH_SKIP;
          end else begin
            r = ROLE_PATH;
            fpos++;
            if (fpos >= PATH_BYTES_DEF - 1) phase = PH_SKIP;
          end
        end
        PH_NAME: r = name_char(b);
        PH_SEP: begin
          if (b == CH_COLON || b == CH_SP) r = ROLE_OTHER;
          else begin phase = PH_VALUE; r = value_char(b); end
        end
        PH_VALUE: r = value_char(b);
        PH_DRAIN: r = is_eol(b) ? ROLE_TERM : ROLE_OTHER;
        default: r = line_skip(b);
      endcase
      if (at_end) begin
        if (flags[2] && lval > 0) begin phase = PH_BODY; body_left = lval; end
        else fin = 1;
      end
      return r;
    endfunction

    function void note_byte(logic [7:0] b);
      int unsigned cnt, n0;
      bit any;
      int full;
      logic [7:0] cp [7];
      fin = 0;
      n0 = pending.size();
      nbytes++;
      if (phase == PH_METHOD) begin
        if (fpos < 7) begin hold[fpos] = b; fpos++; end
        cnt = fpos; any = 0; full = -1;
        for (int m = 0; m < METH_COUNT; m++) begin
          bit ok;
          ok = cnt <= METH_LEN[m];
          for (int i = 0; i < cnt && ok; i++) if (hold[i] != METH_TEXT[m][i]) ok = 0;
          if (ok) begin
            any = 1;
            if (cnt == METH_LEN[m]) full = m;
          end
        end
        if (full >= 0) begin
          mcode = method_t'(full); phase = PH_PATH; fpos = 0;
          for (int i = 0; i < cnt; i++) begin
            tail = ((tail << 8) | hold[i]) & 32'hFF_FFFF;
            push(ROLE_OTHER, hold[i]);
          end
        end else if (!any || cnt >= 7) begin
          cp = hold;
          mcode = METH_UNKNOWN; phase = PH_PATH; fpos = 0;
          for (int i = 0; i < cnt; i++) begin
            role_t r;
            r = classify(cp[i]);
            push(r, cp[i]);
          end
        end else return;
      end else begin
        role_t r;
        r = classify(b);
        push(r, b);
      end
      if (pending.size() > n0) begin
        int k;
        k = pending.size() - 1;
        if (fin) begin
          pending[k].done = 1'b1;
          pending[k].consumed = nbytes[12:0];
          clear();
        end else if (nbytes >= BUFFER_BYTES_DEF) begin
          pending[k].ovf = 1'b1;
          clear();
        end
        pending[k].last = 1'b1;
      end
    endfunction

    function void check_result(parse_res_t got);
      parse_res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  hrsp_tb_clkgen gen();
  wire clk = gen.clk;
  logic rst;
  hrsp_byte_if   stream();
  hrsp_result_if result();

  http_request_stream_parser uut (.clk(clk), .rst(rst), .stream(stream), .result(result));

  parse_scoreboard sb;
  int unsigned cycle_count;
  bit stall_quiet;
  localparam int unsigned CYCLE_LIMIT = 400000;

  initial begin
    sb = new();
    sb.clear();
    sb.errors = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: stall on its own periodic-plus-random pattern unless stall_quiet holds ready high
  always @(posedge clk) begin
    if (rst) result.ready <= 1'b0;
    else if (stall_quiet) result.ready <= 1'b1;
    else result.ready <= ((cycle_count % 23) > 4) && ($urandom_range(0, 5) != 0);
  end

  always @(posedge clk) begin
    if (!rst && stream.valid && stream.ready) sb.note_byte(stream.data_byte);
    if (!rst && result.valid && result.ready) begin
      parse_res_t g;
      g.role = role_t'(result.byte_role); g.data = result.byte_out;
      g.meth = method_t'(result.method); g.done = result.request_done;
      g.clen = result.content_length; g.keep = result.conn_persist;
      g.hdrs = result.header_total; g.consumed = result.consumed_bytes;
      g.ovf = result.overflow_error; g.last = result.last_of_run;
      sb.check_result(g);
    end
  end

  int burst_left;
  int unsigned bytes_sent;

  task automatic send_byte(logic [7:0] b);
    if (burst_left == 0) begin
      int gap;
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        stream.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    stream.valid <= 1'b1;
    stream.data_byte <= b;
    do @(posedge clk); while (!stream.ready);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic string rand_word(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(8'h21, 8'h7E)))};
    return s;
  endfunction

  task automatic send_random_request();
    string meths [6];
    int nh, blen;
    meths = '{"GET ", "POST ", "PUT ", "DELETE ", "HEAD ", "get "};
    send_text(meths[$urandom_range(0, 5)]);
    send_text({"/", rand_word($urandom_range(0, 6)), " HTTP/1.1\r\n"});
    nh = $urandom_range(0, 3);
    blen = 0;
    for (int h = 0; h < nh; h++) begin
      case ($urandom_range(0, 3))
        0: begin
          blen = $urandom_range(0, 6);
          send_text($sformatf("Content-Length: %0d\r\n", blen));
        end
        1: send_text($urandom_range(0, 1) ? "connection: CLOSE\r\n" : "Connection: keep\r\n");
        default: send_text({rand_word($urandom_range(1, 5)), ": ",
                            rand_word($urandom_range(0, 5)), "\r\n"});
      endcase
    end
    send_text("\r\n");
    // body bytes cover all 256 values including NUL
    for (int i = 0; i < blen; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    rst = 1'b1;
    cycle_count = 0;
    stall_quiet = 0;
    burst_left = 0;
    bytes_sent = 0;
    stream.valid = 1'b0;
    stream.data_byte = 8'h00;
    result.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: unknown method with NUL, separator cases, close and length
    send_text("GE");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("\r\n\r\n");
    send_text("HEAD /x\r\nA\r\n\r\n");
    send_text("DELETE \r\n\n\r\n");
    send_text("POST /p HTTP\r\nContent-Length: 2\r\nConnection: close\r\n\r\nab");
    // random part: mostly well-formed requests, plus noise
    while (bytes_sent < 130) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
        stall_quiet = $urandom_range(0, 1);
      end else send_random_request();
    end
    // saturating length: everything after the header end is body
    send_text("PUT / \r\nContent-Length: 99999999999\r\n\r\n");
    send_text("GET / \r\n\r\n");
    stream.valid <= 1'b0;
    stall_quiet = 1;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

### files.f
rtl/hrsp_pkg.sv
rtl/hrsp_if.sv
rtl/http_request_stream_parser.sv
dv/hrsp_tb_if.sv
dv/http_request_stream_parser_tb.sv
